FILE: rtl/rfid_reader_response_parser_macros.svh
// Assertion helpers shared by the parser modules.
// Both expect a clock named clk and a synchronous reset named rst in scope.
`ifndef RFID_READER_RESPONSE_PARSER_MACROS_SVH
`define RFID_READER_RESPONSE_PARSER_MACROS_SVH

// Same-cycle implication.
`define RRP_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define RRP_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/rrp_pkg.sv
`default_nettype none

package rrp_pkg;

  // Frame bytes and decoder constants.
  localparam logic [7:0] FRAME_HEADER    = 8'hA0;
  localparam logic [7:0] CMD_TAG_REPORT  = 8'h8A;
  localparam logic [7:0] CMD_GET_POWER   = 8'h77;
  localparam logic [7:0] CMD_SET_POWER   = 8'h76;
  localparam logic [7:0] CMD_GET_PROFILE = 8'h6A;
  localparam logic [7:0] CMD_SET_PROFILE = 8'h69;
  localparam logic [7:0] CMD_GET_REGION  = 8'h79;
  localparam logic [7:0] CMD_SET_FREQ    = 8'h78;
  localparam logic [7:0] CMD_BEEP        = 8'h7A;
  localparam logic [7:0] STATUS_OK       = 8'h10;
  localparam logic [7:0] POWER_MAX       = 8'h21;
  localparam logic [7:0] BAND_US         = 8'h01;
  localparam logic [7:0] BAND_EU         = 8'h02;
  localparam logic [7:0] BAND_CN         = 8'h03;
  localparam logic [7:0] RANGE_US_HI     = 8'h07;
  localparam logic [7:0] RANGE_US_LO     = 8'h3B;
  localparam logic [7:0] RANGE_VN_HI     = 8'h27;
  localparam logic [7:0] RANGE_VN_LO     = 8'h31;

  // Region codes reported in the value field.
  localparam logic [7:0] REGION_US = 8'd0;
  localparam logic [7:0] REGION_VN = 8'd1;
  localparam logic [7:0] REGION_EU = 8'd2;
  localparam logic [7:0] REGION_CN = 8'd3;

  // Index of the first EPC byte in a tag report frame.
  localparam int EPC_FIRST_INDEX = 7;

  // Result kinds.
  localparam logic [3:0] KIND_EPC         = 4'd0;
  localparam logic [3:0] KIND_POWER       = 4'd1;
  localparam logic [3:0] KIND_SET_POWER   = 4'd2;
  localparam logic [3:0] KIND_PROFILE     = 4'd3;
  localparam logic [3:0] KIND_SET_PROFILE = 4'd4;
  localparam logic [3:0] KIND_REGION      = 4'd5;
  localparam logic [3:0] KIND_SET_FREQ    = 4'd6;
  localparam logic [3:0] KIND_BEEP        = 4'd7;
  localparam logic [3:0] KIND_CHECKSUM    = 4'd8;
  localparam logic [3:0] KIND_EPC_LENGTH  = 4'd9;
  localparam logic [3:0] KIND_POWER_RANGE = 4'd10;
  localparam logic [3:0] KIND_SHORT_FRAME = 4'd11;

  // Header bytes of the current frame, captured as they are stored.
  typedef struct packed {
    logic [7:0] len;
    logic [7:0] cmd;
    logic [7:0] b4;
    logic [7:0] b5;
    logic [7:0] b6;
    logic [7:0] b7;
    logic [7:0] b8;
    logic [7:0] b9;
  } frame_fields_t;

  // Decoder verdict for a frame with a good checksum.
  typedef struct packed {
    logic       single;
    logic       epc_run;
    logic [3:0] kind;
    logic [7:0] value;
    logic       success;
  } decode_t;

  // One result item.
  typedef struct packed {
    logic [3:0]  kind;
    logic [7:0]  value;
    logic        success;
    logic [2:0]  antenna;
    logic [5:0]  frequency_index;
    logic [15:0] protocol_control;
    logic [7:0]  signal_strength;
    logic [6:0]  epc_bytes;
    logic [5:0]  byte_position;
    logic        last;
  } result_t;

endpackage

`default_nettype wire

FILE: rtl/rrp_in_if.sv
`default_nettype none

interface rrp_in_if;
  logic       valid;
  logic       ready;
  logic       func;
  logic [7:0] rx_byte;

  modport source (output valid, output func, output rx_byte, input ready);
  modport sink (input valid, input func, input rx_byte, output ready);
endinterface

`default_nettype wire

FILE: rtl/rrp_out_if.sv
`default_nettype none

interface rrp_out_if;
  logic        valid;
  logic        ready;
  logic [3:0]  kind;
  logic [7:0]  value;
  logic        success;
  logic [2:0]  antenna;
  logic [5:0]  frequency_index;
  logic [15:0] protocol_control;
  logic [7:0]  signal_strength;
  logic [6:0]  epc_bytes;
  logic [5:0]  byte_position;
  logic        last;

  modport source (
    output valid, output kind, output value, output success, output antenna,
    output frequency_index, output protocol_control, output signal_strength,
    output epc_bytes, output byte_position, output last, input ready
  );
  modport sink (
    input valid, input kind, input value, input success, input antenna,
    input frequency_index, input protocol_control, input signal_strength,
    input epc_bytes, input byte_position, input last, output ready
  );
endinterface

`default_nettype wire

FILE: rtl/rrp_frame_store.sv
`default_nettype none

module rrp_frame_store #(
  parameter int DEPTH = 256,
  parameter int AW    = 8
) (
  input  wire logic          clk,
  input  wire logic          wr_en,
  input  wire logic [AW-1:0] wr_addr,
  input  wire logic [7:0]    wr_data,
  input  wire logic          rd_en,
  input  wire logic [AW-1:0] rd_addr,
  output logic      [7:0]    rd_data
);

  logic [7:0] mem [DEPTH];

  // One write port and one registered read port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

FILE: rtl/rrp_decoder.sv
`default_nettype none

module rrp_decoder
  import rrp_pkg::*;
#(
  parameter int MAX_EPC_BYTES = 64
) (
  input  wire frame_fields_t fields,
  input  wire logic          reader_enabled,
  output decode_t            dec
);

  logic [7:0] epc_count;

  assign epc_count = fields.len - 8'd7;

  // Classify the frame by its command byte and the fields it carries.
  always_comb begin
    dec = '0;
    if (fields.len < 8'd3) begin
      dec.single = 1'b1;
      dec.kind   = KIND_SHORT_FRAME;
    end else if (fields.cmd == CMD_TAG_REPORT) begin
      if (reader_enabled) begin
        if (fields.len < 8'd7) begin
          dec.single = 1'b1;
          dec.kind   = KIND_SHORT_FRAME;
        end else if (epc_count == 8'd0 || epc_count > 8'(MAX_EPC_BYTES)) begin
          dec.single = 1'b1;
          dec.kind   = KIND_EPC_LENGTH;
        end else if (!(epc_count == 8'd3 && fields.b7 == 8'd0 &&
                       fields.b8 == 8'd0 && fields.b9 == 8'd0)) begin
          dec.epc_run = 1'b1;
          dec.kind    = KIND_EPC;
        end
      end
    end else if (fields.cmd == CMD_GET_POWER || fields.cmd == CMD_SET_POWER ||
                 fields.cmd == CMD_GET_PROFILE || fields.cmd == CMD_SET_PROFILE ||
                 fields.cmd == CMD_GET_REGION || fields.cmd == CMD_SET_FREQ ||
                 fields.cmd == CMD_BEEP) begin
      if (fields.len < 8'd4) begin
        dec.single = 1'b1;
        dec.kind   = KIND_SHORT_FRAME;
      end else begin
        case (fields.cmd)
          CMD_GET_POWER: begin
            dec.single = 1'b1;
            dec.kind   = (fields.b4 > POWER_MAX) ? KIND_POWER_RANGE : KIND_POWER;
            dec.value  = fields.b4;
          end
          CMD_SET_POWER: begin
            dec.single  = 1'b1;
            dec.kind    = KIND_SET_POWER;
            dec.success = (fields.b4 == STATUS_OK);
          end
          CMD_GET_PROFILE: begin
            dec.single = 1'b1;
            dec.kind   = KIND_PROFILE;
            dec.value  = {6'd0, fields.b4[1:0]};
          end
          CMD_SET_PROFILE: begin
            dec.single  = 1'b1;
            dec.kind    = KIND_SET_PROFILE;
            dec.success = (fields.b4 == STATUS_OK);
          end
          CMD_SET_FREQ: begin
            dec.single  = 1'b1;
            dec.kind    = KIND_SET_FREQ;
            dec.success = (fields.b4 == STATUS_OK);
          end
          CMD_BEEP: begin
            dec.single  = 1'b1;
            dec.kind    = KIND_BEEP;
            dec.success = (fields.b4 == STATUS_OK);
          end
          default: begin
            // Region reply: the band byte, then a range pair for band one.
            dec.kind = KIND_REGION;
            if (fields.b4 == BAND_EU) begin
              dec.single = 1'b1;
              dec.value  = REGION_EU;
            end else if (fields.b4 == BAND_CN) begin
              dec.single = 1'b1;
              dec.value  = REGION_CN;
            end else if (fields.b4 == BAND_US) begin
              if (fields.len < 8'd6) begin
                dec.single = 1'b1;
                dec.kind   = KIND_SHORT_FRAME;
              end else if (fields.b5 == RANGE_US_HI && fields.b6 == RANGE_US_LO) begin
                dec.single = 1'b1;
                dec.value  = REGION_US;
              end else if (fields.b5 == RANGE_VN_HI && fields.b6 == RANGE_VN_LO) begin
                dec.single = 1'b1;
                dec.value  = REGION_VN;
              end
            end
          end
        endcase
      end
    end
  end

endmodule

`default_nettype wire

FILE: rtl/rfid_reader_response_parser.sv
`default_nettype none
`include "rfid_reader_response_parser_macros.svh"

// Reader response frame parser. Bytes (func 0) or flush events (func 1) enter
// on in_ch; decoded results leave on out_ch, the final one of each input
// flagged by last. The input stays ready after a byte that does not end a
// frame; the byte that ends one blocks it while its results drain: a single
// result waits in ST_SINGLE, and a tag report steps through ST_EPC_RD and
// ST_EPC_WR for each EPC byte, as the frame memory has a registered read port.
// Output backpressure holds ST_SINGLE and ST_EPC_WR. Frame memory entries
// are only read after being written in the same frame, so the memory needs
// no clearing after reset. reader_enabled is to be written through cfg_wr_en and
// cfg_wr_data only while the block is idle; the block itself does not enforce it.
module rfid_reader_response_parser
  import rrp_pkg::*;
#(
  parameter int BUFFER_BYTES  = 256,
  parameter int MAX_EPC_BYTES = 64
) (
  input  wire logic   clk,
  input  wire logic   rst,
  input  wire logic   cfg_wr_en,
  input  wire logic   cfg_wr_data,
  rrp_in_if.sink      in_ch,
  rrp_out_if.source   out_ch
);

  localparam int AW = $clog2(BUFFER_BYTES);
  localparam int FW = $clog2(BUFFER_BYTES + 1);
  localparam int CW = (FW > 9) ? FW : 9;

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_SINGLE = 2'd1;
  localparam logic [1:0] ST_EPC_RD = 2'd2;
  localparam logic [1:0] ST_EPC_WR = 2'd3;

  logic [1:0]    state;
  logic          reader_enabled;
  logic          in_frame;
  logic [FW-1:0] fill_count;
  logic [8:0]    expected_total;
  logic [7:0]    running_sum;
  logic [5:0]    pos;
  logic          out_valid;
  result_t       out_item;
  result_t       out_item_next;
  result_t       pend;
  result_t       pend_next;
  frame_fields_t fields;
  logic [7:0]    prev_byte;
  decode_t       dec;
  logic [7:0]    rd_data;
  logic [AW-1:0] rd_addr;

  logic          in_xfer;
  logic          out_free;
  logic          out_load;
  logic [FW-1:0] fill_inc;
  logic [8:0]    len_total;
  logic [8:0]    exp_eff;
  logic          frame_done;
  logic          too_long;
  logic          buf_full;
  logic          sum_ok;
  logic          byte_store;
  logic [6:0]    epc_count;
  logic          epc_last;

  // Handshake and frame bookkeeping.
  assign in_xfer    = in_ch.valid && in_ch.ready;
  assign out_free   = !out_valid || out_ch.ready;
  assign fill_inc   = fill_count + FW'(1);
  assign len_total  = {1'b0, in_ch.rx_byte} + 9'd2;
  assign exp_eff    = (fill_inc == FW'(2)) ? len_total : expected_total;
  assign frame_done = CW'(fill_inc) == CW'(exp_eff);
  assign too_long   = (fill_inc == FW'(2)) && (CW'(len_total) > CW'(BUFFER_BYTES));
  assign buf_full   = CW'(fill_count) >= CW'(BUFFER_BYTES);
  assign sum_ok     = (8'd0 - running_sum) == in_ch.rx_byte;
  assign byte_store = in_xfer && !in_ch.func && in_frame && !buf_full;
  assign in_ch.ready = (state == ST_IDLE);

  // EPC run addressing.
  assign epc_count = 7'(fields.len - 8'd7);
  assign epc_last  = ({1'b0, pos} + 7'd1) == epc_count;
  assign rd_addr   = AW'(EPC_FIRST_INDEX + 32'(pos));

  rrp_frame_store #(
    .DEPTH (BUFFER_BYTES),
    .AW    (AW)
  ) u_store (
    .clk     (clk),
    .wr_en   (byte_store),
    .wr_addr (fill_count[AW-1:0]),
    .wr_data (in_ch.rx_byte),
    .rd_en   (state == ST_EPC_RD),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  rrp_decoder #(
    .MAX_EPC_BYTES (MAX_EPC_BYTES)
  ) u_decoder (
    .fields         (fields),
    .reader_enabled (reader_enabled),
    .dec            (dec)
  );

  // Pending single result chosen when a frame ends.
  always_comb begin
    pend_next         = '0;
    pend_next.last    = 1'b1;
    if (!sum_ok) begin
      pend_next.kind    = KIND_CHECKSUM;
    end else begin
      pend_next.kind    = dec.kind;
      pend_next.value   = dec.value;
      pend_next.success = dec.success;
    end
  end

  // Next output item: the pending single result or the next EPC byte.
  always_comb begin
    if (state == ST_SINGLE) begin
      out_item_next = pend;
    end else begin
      out_item_next                  = '0;
      out_item_next.kind             = KIND_EPC;
      out_item_next.value            = rd_data;
      out_item_next.antenna          = {1'b0, fields.b4[1:0]} + 3'd1;
      out_item_next.frequency_index  = fields.b4[7:2];
      out_item_next.protocol_control = {fields.b5, fields.b6};
      out_item_next.signal_strength  = prev_byte;
      out_item_next.epc_bytes        = epc_count;
      out_item_next.byte_position    = pos;
      out_item_next.last             = epc_last;
    end
  end

  assign out_load = out_free && (state == ST_SINGLE || state == ST_EPC_WR);

  // Control state: frame hunt, fill tracking and result sequencing.
  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= ST_IDLE;
      reader_enabled <= 1'b0;
      in_frame       <= 1'b0;
      fill_count     <= '0;
      expected_total <= '0;
      running_sum    <= '0;
      pos            <= '0;
      out_valid      <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        reader_enabled <= cfg_wr_data;
      end
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (in_xfer) begin
            if (in_ch.func || (in_frame && (buf_full || too_long))) begin
              in_frame       <= 1'b0;
              fill_count     <= '0;
              expected_total <= '0;
              running_sum    <= '0;
            end else if (!in_frame) begin
              if (in_ch.rx_byte == FRAME_HEADER) begin
                in_frame       <= 1'b1;
                fill_count     <= FW'(1);
                expected_total <= '0;
                running_sum    <= FRAME_HEADER;
              end
            end else if (!frame_done) begin
              fill_count  <= fill_inc;
              running_sum <= running_sum + in_ch.rx_byte;
              if (fill_inc == FW'(2)) begin
                expected_total <= len_total;
              end
            end else begin
              in_frame       <= 1'b0;
              fill_count     <= '0;
              expected_total <= '0;
              running_sum    <= '0;
              if (!sum_ok || dec.single) begin
                state <= ST_SINGLE;
              end else if (dec.epc_run) begin
                pos   <= '0;
                state <= ST_EPC_RD;
              end
            end
          end
        end
        ST_SINGLE: begin
          if (out_free) begin
            state <= ST_IDLE;
          end
        end
        ST_EPC_RD: begin
          state <= ST_EPC_WR;
        end
        ST_EPC_WR: begin
          if (out_free) begin
            if (epc_last) begin
              state <= ST_IDLE;
            end else begin
              pos   <= pos + 6'd1;
              state <= ST_EPC_RD;
            end
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // Payload registers: captured header fields, last body byte, results.
  // The body byte before the checksum is the RSSI of a tag report.
  always_ff @(posedge clk) begin
    if (byte_store) begin
      if (!frame_done) begin
        prev_byte <= in_ch.rx_byte;
      end
      case (fill_count)
        FW'(1): fields.len <= in_ch.rx_byte;
        FW'(3): fields.cmd <= in_ch.rx_byte;
        FW'(4): fields.b4  <= in_ch.rx_byte;
        FW'(5): fields.b5  <= in_ch.rx_byte;
        FW'(6): fields.b6  <= in_ch.rx_byte;
        FW'(7): fields.b7  <= in_ch.rx_byte;
        FW'(8): fields.b8  <= in_ch.rx_byte;
        FW'(9): fields.b9  <= in_ch.rx_byte;
        default: begin
        end
      endcase
    end
    if (state == ST_IDLE) begin
      pend <= pend_next;
    end
    if (out_load) begin
      out_item <= out_item_next;
    end
  end

  // Output channel.
  assign out_ch.valid            = out_valid;
  assign out_ch.kind             = out_item.kind;
  assign out_ch.value            = out_item.value;
  assign out_ch.success          = out_item.success;
  assign out_ch.antenna          = out_item.antenna;
  assign out_ch.frequency_index  = out_item.frequency_index;
  assign out_ch.protocol_control = out_item.protocol_control;
  assign out_ch.signal_strength  = out_item.signal_strength;
  assign out_ch.epc_bytes        = out_item.epc_bytes;
  assign out_ch.byte_position    = out_item.byte_position;
  assign out_ch.last             = out_item.last;

  // Checks on the frame tracking and the result sequencing.
  `RRP_ASSERT_NOW(a_hunt_clears_fill, !in_frame, fill_count == '0, "fill count set while hunting")
  `RRP_ASSERT_NOW(a_fill_below_total, in_frame && fill_count >= FW'(2), CW'(fill_count) < CW'(expected_total), "frame fill passed its total")
  `RRP_ASSERT_NOW(a_epc_pos_in_run, out_valid && out_item.kind == KIND_EPC, 7'(out_item.byte_position) < out_item.epc_bytes, "EPC position outside its run")
  `RRP_ASSERT_NEXT(a_single_is_last, state == ST_SINGLE && out_free, out_valid && out_item.last && state == ST_IDLE, "single result not closed")

endmodule

`default_nettype wire

FILE: tb/sv/rfid_reader_response_parser_tb.sv
`timescale 1ns / 1ps

module rfid_reader_response_parser_tb
  import rrp_pkg::*;
;

  localparam int FRAME_BYTES    = 256;
  localparam int EPC_LIMIT      = 64;
  localparam int RANDOM_ITEMS   = 40;
  localparam int HOLD_CYCLES    = 300;
  localparam int SETTLE_CYCLES  = 150;
  localparam int WATCHDOG_LIMIT = 3000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_wr_en;
  logic cfg_wr_data;

  rrp_in_if  in_ch ();
  rrp_out_if out_ch ();

  rfid_reader_response_parser #(
    .BUFFER_BYTES (FRAME_BYTES),
    .MAX_EPC_BYTES(EPC_LIMIT)
  ) dut (
    .clk        (clk),
    .rst        (rst),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .in_ch      (in_ch),
    .out_ch     (out_ch)
  );

  always #5 clk = ~clk;

  // Shared bookkeeping.
  int fail_count    = 0;
  int items_sent    = 0;
  int hold_requests = 0;
  bit burst_mode    = 1'b0;
  int quiet_cycles  = 0;

  // Predictor state: a private copy of the frame collector and the register.
  logic [7:0]  frame_mem [0:FRAME_BYTES-1];
  int unsigned frame_fill;
  int unsigned frame_total;
  bit          collecting;
  logic [7:0]  byte_sum;
  bit          tag_enable;

  // Results expected from the block, oldest first, and those of one transfer.
  result_t expected_q [$];
  result_t step_q [$];

  // Body of the frame under construction: index 2 up to the last byte before
  // the checksum.
  logic [7:0] body_q [$];

  // Gap length: mostly none or short, now and then long.
  function automatic int pick_gap();
    int p;
    p = $urandom_range(0, 99);
    if (p < 55) return 0;
    if (p < 85) return $urandom_range(1, 3);
    if (p < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic result_t plain_result(logic [3:0] k, logic [7:0] v, logic s);
    result_t r;
    r = '0;
    r.kind = k;
    r.value = v;
    r.success = s;
    return r;
  endfunction

  task automatic restart_hunt();
    collecting = 1'b0;
    frame_fill = 0;
    frame_total = 0;
    byte_sum = 8'd0;
  endtask

  // Decode a complete frame with a good checksum into step_q.
  task automatic predict_decode();
    int unsigned len;
    int unsigned n;
    logic [7:0] cmd;
    logic [7:0] b4;
    result_t r;
    len = frame_mem[1];
    if (len < 3) begin
      step_q.push_back(plain_result(KIND_SHORT_FRAME, 8'd0, 1'b0));
      return;
    end
    cmd = frame_mem[3];
    // Tag report: one result per EPC byte.
    if (cmd == CMD_TAG_REPORT) begin
      if (!tag_enable) return;
      if (len < 7) begin
        step_q.push_back(plain_result(KIND_SHORT_FRAME, 8'd0, 1'b0));
        return;
      end
      n = len - 7;
      if (n == 0 || n > EPC_LIMIT) begin
        step_q.push_back(plain_result(KIND_EPC_LENGTH, 8'd0, 1'b0));
        return;
      end
      if (n == 3 && frame_mem[7] == 8'd0 && frame_mem[8] == 8'd0 && frame_mem[9] == 8'd0)
        return;
      for (int i = 0; i < n; i++) begin
        r = '0;
        r.kind = KIND_EPC;
        r.value = frame_mem[EPC_FIRST_INDEX + i];
        r.antenna = {1'b0, frame_mem[4][1:0]} + 3'd1;
        r.frequency_index = frame_mem[4][7:2];
        r.protocol_control = {frame_mem[5], frame_mem[6]};
        r.signal_strength = frame_mem[EPC_FIRST_INDEX + n];
        r.epc_bytes = 7'(n);
        r.byte_position = 6'(i);
        step_q.push_back(r);
      end
      return;
    end
    case (cmd)
      CMD_GET_POWER, CMD_SET_POWER, CMD_GET_PROFILE, CMD_SET_PROFILE,
      CMD_GET_REGION, CMD_SET_FREQ, CMD_BEEP: ;
      default: return;
    endcase
    if (len < 4) begin
      step_q.push_back(plain_result(KIND_SHORT_FRAME, 8'd0, 1'b0));
      return;
    end
    b4 = frame_mem[4];
    case (cmd)
      CMD_GET_POWER:
        step_q.push_back(plain_result(b4 > POWER_MAX ? KIND_POWER_RANGE : KIND_POWER,
                                      b4, 1'b0));
      CMD_SET_POWER:
        step_q.push_back(plain_result(KIND_SET_POWER, 8'd0, b4 == STATUS_OK));
      CMD_GET_PROFILE:
        step_q.push_back(plain_result(KIND_PROFILE, {6'd0, b4[1:0]}, 1'b0));
      CMD_SET_PROFILE:
        step_q.push_back(plain_result(KIND_SET_PROFILE, 8'd0, b4 == STATUS_OK));
      CMD_SET_FREQ:
        step_q.push_back(plain_result(KIND_SET_FREQ, 8'd0, b4 == STATUS_OK));
      CMD_BEEP:
        step_q.push_back(plain_result(KIND_BEEP, 8'd0, b4 == STATUS_OK));
      default: begin
        // Region reply.
        if (b4 == BAND_EU) begin
          step_q.push_back(plain_result(KIND_REGION, REGION_EU, 1'b0));
        end else if (b4 == BAND_CN) begin
          step_q.push_back(plain_result(KIND_REGION, REGION_CN, 1'b0));
        end else if (b4 == BAND_US) begin
          if (len < 6)
            step_q.push_back(plain_result(KIND_SHORT_FRAME, 8'd0, 1'b0));
          else if (frame_mem[5] == RANGE_US_HI && frame_mem[6] == RANGE_US_LO)
            step_q.push_back(plain_result(KIND_REGION, REGION_US, 1'b0));
          else if (frame_mem[5] == RANGE_VN_HI && frame_mem[6] == RANGE_VN_LO)
            step_q.push_back(plain_result(KIND_REGION, REGION_VN, 1'b0));
        end
      end
    endcase
  endtask

  // Work out the results of one accepted transfer and queue them.
  task automatic predict_item(input logic flush, input logic [7:0] b);
    logic [7:0] want_sum;
    result_t r;
    step_q.delete();
    if (flush) begin
      restart_hunt();
      return;
    end
    if (!collecting) begin
      if (b == FRAME_HEADER) begin
        collecting = 1'b1;
        frame_mem[0] = b;
        frame_fill = 1;
        frame_total = 0;
        byte_sum = b;
      end
      return;
    end
    if (frame_fill >= FRAME_BYTES) begin
      restart_hunt();
      return;
    end
    frame_mem[frame_fill] = b;
    frame_fill++;
    if (frame_fill == 2) begin
      frame_total = b + 2;
      if (frame_total > FRAME_BYTES) begin
        restart_hunt();
        return;
      end
    end
    if (frame_fill != frame_total) begin
      byte_sum = byte_sum + b;
      return;
    end
    want_sum = 8'd0 - byte_sum;
    if (want_sum != b)
      step_q.push_back(plain_result(KIND_CHECKSUM, 8'd0, 1'b0));
    else
      predict_decode();
    restart_hunt();
    if (step_q.size() > 0) begin
      r = step_q.pop_back();
      r.last = 1'b1;
      step_q.push_back(r);
    end
    while (step_q.size() > 0) expected_q.push_back(step_q.pop_front());
  endtask

  // Offer one item after a random gap and wait for its transfer.
  task automatic send_item(input logic flush, input logic [7:0] b);
    int gap;
    gap = burst_mode ? 0 : pick_gap();
    if (gap > 0) begin
      @(negedge clk);
      in_ch.valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_ch.valid <= 1'b1;
    in_ch.func <= flush;
    in_ch.rx_byte <= b;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
    predict_item(flush, b);
    items_sent++;
  endtask

  task automatic send_flush();
    send_item(1'b1, 8'($urandom_range(0, 255)));
  endtask

  // Send header, length, body_q and checksum; a bad checksum is corrupted.
  task automatic send_frame(input bit bad_sum);
    logic [7:0] len;
    logic [7:0] sum;
    len = 8'(body_q.size() + 1);
    sum = FRAME_HEADER + len;
    for (int i = 0; i < body_q.size(); i++) sum = sum + body_q[i];
    sum = 8'd0 - sum;
    if (bad_sum) sum = sum ^ 8'($urandom_range(1, 255));
    send_item(1'b0, FRAME_HEADER);
    send_item(1'b0, len);
    for (int i = 0; i < body_q.size(); i++) send_item(1'b0, body_q[i]);
    send_item(1'b0, sum);
    body_q.delete();
  endtask

  task automatic start_body(input logic [7:0] cmd);
    body_q.delete();
    body_q.push_back(8'($urandom_range(0, 255)));
    body_q.push_back(cmd);
  endtask

  task automatic send_reply(input logic [7:0] cmd, input logic [7:0] b4);
    start_body(cmd);
    body_q.push_back(b4);
    send_frame(1'b0);
  endtask

  task automatic send_tag(input int n, input logic [7:0] info, input logic [15:0] pc,
                          input logic [7:0] rssi, input bit zeros);
    start_body(CMD_TAG_REPORT);
    body_q.push_back(info);
    body_q.push_back(pc[15:8]);
    body_q.push_back(pc[7:0]);
    for (int i = 0; i < n; i++) body_q.push_back(zeros ? 8'd0 : 8'($urandom_range(0, 255)));
    body_q.push_back(rssi);
    send_frame(1'b0);
  endtask

  task automatic send_random_tag(input int n);
    send_tag(n, 8'($urandom_range(0, 255)), 16'($urandom_range(0, 65535)),
             8'($urandom_range(0, 255)), 1'b0);
  endtask

  task automatic send_region(input logic [7:0] band, input logic [7:0] hi,
                             input logic [7:0] lo, input int extra);
    start_body(CMD_GET_REGION);
    body_q.push_back(band);
    if (extra > 0) body_q.push_back(hi);
    if (extra > 1) body_q.push_back(lo);
    send_frame(1'b0);
  endtask

  // Stop offering, wait for every expected result, then let the block go idle.
  task automatic settle_block();
    @(negedge clk);
    in_ch.valid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_enable(input logic v);
    settle_block();
    @(negedge clk);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= v;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    tag_enable = v;
  endtask

  function automatic void check_field(string name, logic [15:0] want_v, logic [15:0] got_v);
    if (got_v !== want_v) begin
      $error("%s mismatch: expected %0h, actual %0h", name, want_v, got_v);
      fail_count++;
    end
  endfunction

  // Tag reports are dropped while the reader is disabled; replies still pass.
  task automatic test_disabled_tag_report();
    write_enable(1'b0);
    send_random_tag(4);
    send_reply(CMD_GET_POWER, 8'h10);
  endtask

  task automatic test_tag_reports();
    write_enable(1'b1);
    send_tag(1, 8'hFF, 16'hFFFF, 8'hFF, 1'b0);
    send_tag(1, 8'h00, 16'h0000, 8'h00, 1'b0);
    // A three-byte all-zero EPC is suppressed; a nonzero one is not.
    send_tag(3, 8'h5A, 16'h3000, 8'h80, 1'b1);
    send_tag(3, 8'hA7, 16'h3000, 8'h80, 1'b0);
  endtask

  task automatic test_epc_errors();
    send_random_tag(0);
    send_random_tag(EPC_LIMIT + 1);
    // Tag reports too short to hold an EPC: none past the command, or up to the PC word.
    for (int k = 0; k < 4; k += 3) begin
      start_body(CMD_TAG_REPORT);
      for (int i = 0; i < k; i++) body_q.push_back(8'($urandom_range(0, 255)));
      send_frame(1'b0);
    end
  endtask

  task automatic test_short_frames();
    body_q.delete();
    send_frame(1'b0);
    body_q.push_back(8'h01);
    send_frame(1'b0);
    start_body(CMD_GET_POWER);
    send_frame(1'b0);
  endtask

  task automatic test_commands();
    send_reply(CMD_GET_POWER, 8'h00);
    send_reply(CMD_GET_POWER, POWER_MAX);
    send_reply(CMD_GET_POWER, POWER_MAX + 8'd1);
    send_reply(CMD_SET_POWER, STATUS_OK);
    send_reply(CMD_SET_POWER, 8'h11);
    send_reply(CMD_GET_PROFILE, 8'hFF);
    send_reply(CMD_SET_PROFILE, STATUS_OK);
    send_reply(CMD_SET_FREQ, 8'hEF);
    send_reply(CMD_BEEP, STATUS_OK);
    // Unknown commands give nothing.
    send_reply(8'h8B, STATUS_OK);
  endtask

  task automatic test_regions();
    send_region(BAND_EU, 8'h00, 8'h00, 0);
    send_region(BAND_CN, 8'h00, 8'h00, 0);
    send_region(BAND_US, RANGE_US_HI, RANGE_US_LO, 2);
    send_region(BAND_US, RANGE_VN_HI, RANGE_VN_LO, 2);
    send_region(BAND_US, RANGE_US_HI, RANGE_VN_LO, 2);
    send_region(BAND_US, RANGE_US_HI, 8'h00, 1);
    send_region(8'h00, 8'h00, 8'h00, 0);
  endtask

  task automatic test_framing();
    // Noise while hunting for the header.
    send_item(1'b0, 8'h00);
    send_item(1'b0, 8'hFF);
    send_item(1'b0, 8'h5F);
    send_reply(CMD_BEEP, STATUS_OK);
    // Checksum mismatch.
    start_body(CMD_GET_POWER);
    body_q.push_back(8'h10);
    send_frame(1'b1);
    // Empty length: the length byte is taken as the checksum.
    send_item(1'b0, FRAME_HEADER);
    send_item(1'b0, 8'h00);
    // Oversized length restarts the hunt.
    send_item(1'b0, FRAME_HEADER);
    send_item(1'b0, 8'hFF);
    send_item(1'b0, 8'h12);
    send_reply(CMD_SET_POWER, STATUS_OK);
    // A flush event drops a partial frame.
    send_item(1'b0, FRAME_HEADER);
    send_item(1'b0, 8'h04);
    send_item(1'b0, 8'h01);
    send_flush();
    send_reply(CMD_GET_PROFILE, 8'h01);
  endtask

  // The receiver holds off while frames keep coming, so the block fills up.
  task automatic test_backpressure();
    write_enable(1'b1);
    burst_mode = 1'b1;
    hold_requests++;
    send_random_tag(EPC_LIMIT);
    send_reply(CMD_GET_POWER, 8'h15);
    send_reply(CMD_BEEP, STATUS_OK);
    burst_mode = 1'b0;
    settle_block();
  endtask

  task automatic test_random();
    int start_items;
    int round;
    int pick;
    int n;
    logic [7:0] cmd;
    logic [7:0] b4;
    start_items = items_sent;
    round = 0;
    while (items_sent < start_items + RANDOM_ITEMS) begin
      round++;
      if (round % 30 == 0) write_enable($urandom_range(0, 99) < 70);
      if ($urandom_range(0, 99) < 5) burst_mode = !burst_mode;
      pick = $urandom_range(0, 99);
      if (pick < 35) begin
        n = $urandom_range(0, 99);
        if (n < 80) send_random_tag($urandom_range(1, 6));
        else if (n < 88) send_tag(3, 8'($urandom_range(0, 255)), 16'h3000, 8'h7F, 1'b1);
        else if (n < 93) send_random_tag($urandom_range(0, 1) ? 0 : EPC_LIMIT + 1);
        else send_random_tag($urandom_range(7, EPC_LIMIT));
      end else if (pick < 65) begin
        case ($urandom_range(0, 8))
          0: cmd = CMD_GET_POWER;
          1: cmd = CMD_SET_POWER;
          2: cmd = CMD_GET_PROFILE;
          3: cmd = CMD_SET_PROFILE;
          4: cmd = CMD_SET_FREQ;
          5: cmd = CMD_BEEP;
          6: cmd = CMD_GET_REGION;
          7: cmd = 8'h8B;
          default: cmd = 8'($urandom_range(0, 255));
        endcase
        if (cmd == CMD_GET_POWER && $urandom_range(0, 99) < 70)
          b4 = 8'($urandom_range(0, POWER_MAX));
        else if ($urandom_range(0, 1))
          b4 = STATUS_OK;
        else
          b4 = 8'($urandom_range(0, 255));
        send_reply(cmd, b4);
      end else if (pick < 75) begin
        case ($urandom_range(0, 3))
          0: b4 = BAND_EU;
          1: b4 = BAND_CN;
          2: b4 = BAND_US;
          default: b4 = 8'($urandom_range(0, 255));
        endcase
        n = $urandom_range(0, 99) < 15 ? $urandom_range(0, 1) : 2;
        case ($urandom_range(0, 2))
          0: send_region(b4, RANGE_US_HI, RANGE_US_LO, n);
          1: send_region(b4, RANGE_VN_HI, RANGE_VN_LO, n);
          default: send_region(b4, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)), n);
        endcase
      end else if (pick < 83) begin
        // Frames too short for their command or value byte.
        body_q.delete();
        n = $urandom_range(0, 2);
        for (int i = 0; i < n; i++) body_q.push_back(8'($urandom_range(0, 255)));
        send_frame(1'b0);
      end else if (pick < 89) begin
        start_body(8'($urandom_range(0, 255)));
        n = $urandom_range(0, 6);
        for (int i = 0; i < n; i++) body_q.push_back(8'($urandom_range(0, 255)));
        send_frame(1'b1);
      end else if (pick < 94) begin
        n = $urandom_range(1, 6);
        for (int i = 0; i < n; i++) send_item(1'b0, 8'($urandom_range(0, 255)));
        send_flush();
      end else begin
        // Truncated or oversized frame, then a flush to resynchronize.
        send_item(1'b0, FRAME_HEADER);
        if ($urandom_range(0, 3) == 0) begin
          send_item(1'b0, 8'hFF);
        end else begin
          n = $urandom_range(3, 40);
          send_item(1'b0, 8'(n));
          repeat ($urandom_range(0, n - 1)) send_item(1'b0, 8'($urandom_range(0, 255)));
        end
        send_flush();
      end
    end
    burst_mode = 1'b0;
  endtask

  // Receiver: random stalls, plus a long hold-off on request.
  initial begin
    int hold_left;
    int stall_left;
    int hold_seen;
    hold_left = 0;
    stall_left = 0;
    hold_seen = 0;
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_seen != hold_requests) begin
        hold_seen = hold_requests;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else if (stall_left > 0 && !burst_mode) begin
        stall_left--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
        if (!burst_mode && $urandom_range(0, 99) < 30) stall_left = pick_gap();
      end
    end
  end

  // Compare each result transfer with the oldest expectation.
  always @(posedge clk) begin
    result_t want;
    if (!rst && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
      if (expected_q.size() == 0) begin
        $error("unexpected result: kind %0d value %0h", out_ch.kind, out_ch.value);
        fail_count++;
      end else begin
        want = expected_q.pop_front();
        check_field("kind", want.kind, out_ch.kind);
        check_field("value", want.value, out_ch.value);
        check_field("success", want.success, out_ch.success);
        check_field("antenna", want.antenna, out_ch.antenna);
        check_field("frequency_index", want.frequency_index, out_ch.frequency_index);
        check_field("protocol_control", want.protocol_control, out_ch.protocol_control);
        check_field("signal_strength", want.signal_strength, out_ch.signal_strength);
        check_field("epc_bytes", want.epc_bytes, out_ch.epc_bytes);
        check_field("byte_position", want.byte_position, out_ch.byte_position);
        check_field("last", want.last, out_ch.last);
      end
    end
  end

  // Watchdog on cycles without any transfer.
  always @(posedge clk) begin
    if ((in_ch.valid === 1'b1 && in_ch.ready === 1'b1) ||
        (out_ch.valid === 1'b1 && out_ch.ready === 1'b1)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("Test completed with failures");
        $finish;
      end
    end
  end

  initial begin
    in_ch.valid = 1'b0;
    in_ch.func = 1'b0;
    in_ch.rx_byte = 8'd0;
    cfg_wr_en = 1'b0;
    cfg_wr_data = 1'b0;
    restart_hunt();
    tag_enable = 1'b0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_disabled_tag_report();
    test_tag_reports();
    test_epc_errors();
    test_short_frames();
    test_commands();
    test_regions();
    test_framing();
    test_backpressure();
    test_random();
    settle_block();

    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

FILE: rfid_reader_response_parser.f
+incdir+rtl
rtl/rrp_pkg.sv
rtl/rrp_in_if.sv
rtl/rrp_out_if.sv
rtl/rrp_frame_store.sv
rtl/rrp_decoder.sv
rtl/rfid_reader_response_parser.sv
tb/sv/rfid_reader_response_parser_tb.sv
